FILE: sv/pthd_pkg.sv
// ----------------------------------------------------------------------------
// pthd_pkg: shared types and constants for the path heading block
// Holds the CORDIC arctangent table, fixed widths and the command word
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package pthd_pkg;

  // Extra fractional bits added to the step vector before rotation.
  localparam int GUARD_BITS = 8;
  // Entries in the arctangent table; later iterations are not performed.
  localparam int TABLE_LEN  = 24;
  localparam int TBL_IDX_W  = 5;
  // The angle accumulator counts 2^-32 turn per unit.
  localparam int ACC_W      = 32;

  // Saturation value of the per-path heading counter.
  localparam logic [1:0] HCNT_MAX = 2'd2;

  // Command word from the controller to the datapath.
  typedef struct packed {
    logic                 load;       // capture a point and form the step
    logic                 prep;       // set up the CORDIC vector
    logic                 step;       // one CORDIC iteration
    logic [TBL_IDX_W-1:0] step_idx;   // iteration number
    logic                 push_new;   // send the fresh heading
    logic                 push_last;  // send the stored heading again
  } pthd_cmd_t;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
  function automatic logic [ACC_W-1:0] atan_turn(input logic [TBL_IDX_W-1:0] idx);
    logic [ACC_W-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/pthd_point_if.sv
// ----------------------------------------------------------------------------
// pthd_point_if: path point channel
// Valid/ready channel that carries one path point per word.
// ----------------------------------------------------------------------------
interface pthd_point_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         final_point;

  modport source (output valid, output point_x, output point_y, output final_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input final_point,
                  output ready);
endinterface

FILE: sv/pthd_heading_if.sv
// ----------------------------------------------------------------------------
// pthd_heading_if: heading channel
// Valid/ready channel that carries one heading word per transfer.
// ----------------------------------------------------------------------------
interface pthd_heading_if #(
  parameter int ANGLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] heading;
  logic                         run_end;

  modport source (output valid, output heading, output run_end, input ready);
  modport sink   (input valid, input heading, input run_end, output ready);
endinterface

FILE: sv/pthd_dp.sv
// ----------------------------------------------------------------------------
// pthd_dp: path heading datapath
// Previous point, step vector, iterative CORDIC and the heading registers.
// ----------------------------------------------------------------------------
module pthd_dp #(
  parameter int COORD_BITS = 32,
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  pthd_pkg::pthd_cmd_t          cmd,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  output logic signed [ANGLE_BITS-1:0] out_heading
);
  import pthd_pkg::*;

  localparam int DW = COORD_BITS + 1;            // step width
  localparam int W  = DW + GUARD_BITS + 3;       // room for CORDIC gain
  localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (ACC_W - ANGLE_BITS - 1);
  localparam logic [ACC_W-1:0] HALF_TURN = ACC_W'(1) << (ACC_W - 1);

  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic signed [DW-1:0]         dx_r, dy_r;
  logic signed [W-1:0]          x_r, y_r;
  logic [ACC_W-1:0]             z_r;
  logic                         zero_r;
  logic signed [ANGLE_BITS-1:0] last_heading_r, out_heading_r;

  logic signed [DW-1:0]         dx_nxt, dy_nxt;
  logic signed [W-1:0]          x_ext, y_ext, x_sh, y_sh;
  logic [ACC_W-1:0]             z_round;
  logic [ACC_W-1:0]             atan_val;
  logic signed [ANGLE_BITS-1:0] heading_new;

  assign dx_nxt = {in_x[COORD_BITS-1], in_x} - {prev_x_r[COORD_BITS-1], prev_x_r};
  assign dy_nxt = {in_y[COORD_BITS-1], in_y} - {prev_y_r[COORD_BITS-1], prev_y_r};

  assign x_ext = {{(W-DW){dx_r[DW-1]}}, dx_r} <<< GUARD_BITS;
  assign y_ext = {{(W-DW){dy_r[DW-1]}}, dy_r} <<< GUARD_BITS;

  assign x_sh     = x_r >>> cmd.step_idx;
  assign y_sh     = y_r >>> cmd.step_idx;
  assign atan_val = atan_turn(cmd.step_idx);

  // Round to nearest at the output resolution; the turn wraps naturally.
  assign z_round     = z_r + HALF_LSB;
  assign heading_new = zero_r ? '0 : z_round[ACC_W-1 -: ANGLE_BITS];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_x_r <= in_x;
      prev_y_r <= in_y;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
    end
    if (cmd.prep) begin
      // A step pointing left is turned by a half turn into the right half plane.
      zero_r <= (dx_r == '0) && (dy_r == '0);
      if (dx_r[DW-1]) begin
        x_r <= -x_ext;
        y_r <= -y_ext;
        z_r <= HALF_TURN;
      end else begin
        x_r <= x_ext;
        y_r <= y_ext;
        z_r <= '0;
      end
    end
    if (cmd.step) begin
      if (!y_r[W-1]) begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + atan_val;
      end else begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - atan_val;
      end
    end
    if (cmd.push_new) begin
      out_heading_r  <= heading_new;
      last_heading_r <= heading_new;
    end else if (cmd.push_last) begin
      out_heading_r <= last_heading_r;
    end
  end

  assign out_heading = out_heading_r;

endmodule

FILE: sv/pthd_ctrl.sv
// ----------------------------------------------------------------------------
// pthd_ctrl: path heading controller
// Sequences point capture, CORDIC iterations and result words, and keeps
// the per-path bookkeeping and the output valid flag.
// ----------------------------------------------------------------------------
module pthd_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_final,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_run_end,
  output pthd_pkg::pthd_cmd_t cmd
);
  import pthd_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int SW     = $clog2(NSTEPS);
  localparam logic [SW-1:0] LAST_STEP = SW'(NSTEPS - 1);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_ITER, S_EMIT1, S_EMIT2} state_t;

  state_t        state_r, state_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic [1:0]    hcnt_r, hcnt_nxt;
  logic          fin_r, fin_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_run_end_r, out_run_end_nxt;
  logic          slot_free;
  logic [1:0]    hcnt_inc;
  logic          repeat_last;

  assign slot_free   = !out_valid_r || out_ready;
  assign hcnt_inc    = (hcnt_r == HCNT_MAX) ? HCNT_MAX : hcnt_r + 2'd1;
  assign repeat_last = fin_r && (hcnt_inc == HCNT_MAX);

  always_comb begin
    state_nxt       = state_r;
    have_prev_nxt   = have_prev_r;
    hcnt_nxt        = hcnt_r;
    fin_nxt         = fin_r;
    step_nxt        = step_r;
    out_valid_nxt   = out_valid_r;
    out_run_end_nxt = out_run_end_r;
    cmd             = '0;
    cmd.step_idx    = TBL_IDX_W'(step_r);
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (have_prev_r) begin
            fin_nxt   = in_final;
            state_nxt = S_PREP;
          end else begin
            // A lone final point ends the path with nothing to report.
            have_prev_nxt = !in_final;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.step = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_EMIT1;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_EMIT1: begin
        if (slot_free) begin
          cmd.push_new    = 1'b1;
          out_valid_nxt   = 1'b1;
          out_run_end_nxt = fin_r && !repeat_last;
          hcnt_nxt        = hcnt_inc;
          if (repeat_last) begin
            state_nxt = S_EMIT2;
          end else begin
            state_nxt = S_IDLE;
            if (fin_r) begin
              have_prev_nxt = 1'b0;
              hcnt_nxt      = '0;
            end
          end
        end
      end
      S_EMIT2: begin
        if (slot_free) begin
          cmd.push_last   = 1'b1;
          out_valid_nxt   = 1'b1;
          out_run_end_nxt = 1'b1;
          have_prev_nxt   = 1'b0;
          hcnt_nxt        = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      have_prev_r   <= 1'b0;
      hcnt_r        <= '0;
      out_valid_r   <= 1'b0;
      out_run_end_r <= 1'b0;
      fin_r         <= 1'b0;
      step_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      have_prev_r   <= have_prev_nxt;
      hcnt_r        <= hcnt_nxt;
      out_valid_r   <= out_valid_nxt;
      out_run_end_r <= out_run_end_nxt;
      fin_r         <= fin_nxt;
      step_r        <= step_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_run_end = out_run_end_r;

endmodule

FILE: sv/path_heading_from_points.sv
// ----------------------------------------------------------------------------
// path_heading_from_points: heading of each step along a path
// Each point with a predecessor is captured, sets up the vector, runs the CORDIC
//   iterations and then emits its heading word into the output register. The
//   single shared CORDIC stage takes no new point until the last is through;
//   a final point that repeats its heading emits one more word, and a first
//   point only updates the stored point.
// Reset: synchronous, active low; it clears the path state and the output valid flag.
// ----------------------------------------------------------------------------
module path_heading_from_points #(
  parameter int COORD_BITS   = 32,
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  pthd_point_if.sink     in_chan,
  pthd_heading_if.source out_chan
);
  import pthd_pkg::*;

  // The block keeps the previous point of the current path. Each new point
  // after the first forms the step vector from the previous point, and the
  // datapath rotates that vector onto the positive x axis with a vectoring
  // CORDIC, one iteration per cycle, while the angle accumulator sums the
  // table arctangents. Steps that point left are first turned by a half turn.
  // A step of zero length reports a heading of zero.
  //
  // Path bookkeeping lives in the controller: whether a previous point is
  // held and how many headings the path has produced so far (saturating at
  // two). On the final point, a path that produced at least two headings
  // sends its last heading once more, and the last word of the path carries
  // run_end. After the final point the path state returns to its reset value.
  //
  // The result word sits in an output register, so the block takes the next
  // point while a finished word still waits for the sink.

  pthd_cmd_t cmd;

  pthd_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_final    (in_chan.final_point),
    .in_ready    (in_chan.ready),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_run_end (out_chan.run_end),
    .cmd         (cmd)
  );

  pthd_dp #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .in_x        (in_chan.point_x),
    .in_y        (in_chan.point_y),
    .out_heading (out_chan.heading)
  );

  // The controller issues at most one datapath operation per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.prep, cmd.step, cmd.push_new, cmd.push_last}))
    else $error("more than one datapath command in a cycle");

  // Vector setup is always followed by the first CORDIC iteration.
  a_prep_then_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prep |=> (cmd.step && cmd.step_idx == '0))
    else $error("CORDIC did not start after setup");

  // A pushed heading is presented to the sink in the next cycle.
  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_new || cmd.push_last) |=> out_chan.valid)
    else $error("heading word pushed but not presented");

endmodule

FILE: dv/tb_path_heading_from_points.sv
// ----------------------------------------------------------------------------
// tb_path_heading_from_points: self-checking bench for the path heading block
// Streams paths of points into the block and predicts every heading word with
// a bit-exact CORDIC of its own. A scoreboard compares each heading word that
// leaves the block, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_path_heading_from_points;

  import pthd_pkg::*;

  localparam int COORD_BITS   = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  // Handy coordinates. One unit in Q16.16 is 2^16.
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_BITS-1:0] UNIT      = 32'sh0001_0000;

  // Rough stimulus size; the random part stops once this many points went in.
  localparam int POINT_TARGET = 750;
  // One long receiver hold-off after the first 80 headings, then after every HOLD_EVERY more.
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_EVERY   = 600;
  // After the last owed heading the drain waits long enough for two more
  // headings plus a margin before the verdict.
  localparam int DRAIN_CYCLES = 2 * (CORDIC_STEPS + 3) + 8;
  // Cycles without any word moving on either channel before we give up.
  // The longest honest quiet spell is the hold-off plus a long sender gap, a
  // long receiver stall and one CORDIC pass.
  localparam int QUIET_LIMIT  = 4000;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
  localparam bit [31:0] STEP_ANGLE [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic [ANGLE_BITS-1:0] heading;
    logic                  run_end;
  } heading_word_t;

  // Keeps its own copy of the path state and a queue of heading words that
  // the block still owes us.
  class heading_scoreboard;
    int            errors;
    heading_word_t headings_due[$];
    longint        prev_x;
    longint        prev_y;
    bit            have_prev;
    int            emitted;
    bit [ANGLE_BITS-1:0] last_heading;

    function new();
      errors = 0;
      clear_path();
    endfunction

    function void clear_path();
      prev_x       = 0;
      prev_y       = 0;
      have_prev    = 1'b0;
      emitted      = 0;
      last_heading = '0;
    endfunction

    // Vectoring CORDIC on the step scaled by the guard bits. The accumulator
    // counts 2^-32 turn and wraps modulo one turn.
    function bit [ANGLE_BITS-1:0] cordic_heading(longint dx, longint dy);
      longint    vx;
      longint    vy;
      longint    nx;
      bit [31:0] acc;
      bit [32:0] rounded;
      if (dx == 0 && dy == 0) begin
        return '0;
      end
      vx  = dx * (longint'(1) << GUARD_BITS);
      vy  = dy * (longint'(1) << GUARD_BITS);
      acc = '0;
      if (vx < 0) begin
        vx  = -vx;
        vy  = -vy;
        acc = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
        if (vy >= 0) begin
          nx  = vx + (vy >>> i);
          vy  = vy - (vx >>> i);
          acc = acc + STEP_ANGLE[i];
        end else begin
          nx  = vx - (vy >>> i);
          vy  = vy + (vx >>> i);
          acc = acc - STEP_ANGLE[i];
        end
        vx = nx;
      end
      rounded = {1'b0, acc} + (33'd1 << (31 - ANGLE_BITS));
      return rounded[31 -: ANGLE_BITS];
    endfunction

    function int pending();
      return headings_due.size();
    endfunction

    // Called for every point word that the block accepted.
    function void note_point(logic signed [COORD_BITS-1:0] px,
                             logic signed [COORD_BITS-1:0] py, logic fin);
      longint        x;
      longint        y;
      heading_word_t w;
      x = px;
      y = py;
      if (have_prev) begin
        last_heading = cordic_heading(x - prev_x, y - prev_y);
        if (emitted < 2) begin
          emitted++;
        end
        // A path with a single heading ends on that heading; longer paths
        // end on the repeated one.
        w.heading = last_heading;
        w.run_end = fin && (emitted < 2);
        headings_due.push_back(w);
      end
      if (fin) begin
        if (emitted >= 2) begin
          w.heading = last_heading;
          w.run_end = 1'b1;
          headings_due.push_back(w);
        end
        clear_path();
      end else begin
        prev_x    = x;
        prev_y    = y;
        have_prev = 1'b1;
      end
    endfunction

    task report(string msg);
      // Only the first couple hundred are printed so a broken block cannot
      // flood the log; all of them are counted.
      if (errors < 200) begin
        $display("%0t mismatch: %s", $time, msg);
      end
      errors++;
    endtask

    task check_heading(logic [ANGLE_BITS-1:0] heading, logic run_end);
      heading_word_t w;
      if (headings_due.size() == 0) begin
        report($sformatf("heading word %0d run_end %0b with none expected",
                         $signed(heading), run_end));
      end else begin
        w = headings_due.pop_front();
        if (heading !== w.heading) begin
          report($sformatf("heading %0d, expected %0d",
                           $signed(heading), $signed(w.heading)));
        end
        if (run_end !== w.run_end) begin
          report($sformatf("run_end %0b, expected %0b (heading %0d)",
                           run_end, w.run_end, $signed(w.heading)));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pthd_point_if   #(.COORD_BITS(COORD_BITS)) pts ();
  pthd_heading_if #(.ANGLE_BITS(ANGLE_BITS)) hdg ();

  path_heading_from_points #(
    .COORD_BITS  (COORD_BITS),
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (pts),
    .out_chan(hdg)
  );

  heading_scoreboard sb;

  always #2 clk = ~clk;

  // Idle lengths: mostly none or short ones, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 16);
    end
    return $urandom_range(17, 60);
  endfunction

  // Offers one point word after an optional idle gap and returns once the
  // block has taken it. Ready is looked at just after the edge, so it is the
  // value the block presented at that edge.
  task automatic send_point(logic signed [COORD_BITS-1:0] px,
                            logic signed [COORD_BITS-1:0] py,
                            logic fin, int gap);
    if (gap > 0) begin
      pts.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pts.valid       <= 1'b1;
    pts.point_x     <= px;
    pts.point_y     <= py;
    pts.final_point <= fin;
    do @(posedge clk); while (pts.ready !== 1'b1);
    sb.note_point(px, py, fin);
  endtask

  // Picks the next point of a random path. Half of the steps are modest or tiny
  // moves from the previous point; the rest are full-range jumps, repeats of the
  // same point (zero step), moves along an axis and the coordinate extremes.
  task automatic next_point(inout logic signed [COORD_BITS-1:0] px,
                            inout logic signed [COORD_BITS-1:0] py);
    int kind;
    int dx;
    int dy;
    kind = $urandom_range(9);
    dx   = $urandom_range(2097152) - 1048576;
    dy   = $urandom_range(2097152) - 1048576;
    case (kind)
      0, 1, 2, 3: begin
        px = px + dx;
        py = py + dy;
      end
      4: begin
        // Tiny steps exercise the CORDIC on short vectors.
        px = px + ($urandom_range(6) - 3);
        py = py + ($urandom_range(6) - 3);
      end
      5, 6: begin
        px = $urandom;
        py = $urandom;
      end
      7: begin
        // Same point again: a zero step.
      end
      8: begin
        if ($urandom_range(1)) begin
          px = ($urandom_range(1)) ? px + dx : $urandom;
        end else begin
          py = ($urandom_range(1)) ? py + dy : $urandom;
        end
      end
      default: begin
        case ($urandom_range(3))
          0:       px = COORD_MIN;
          1:       px = COORD_MAX;
          2:       px = '0;
          default: px = '1;
        endcase
        case ($urandom_range(3))
          0:       py = COORD_MIN;
          1:       py = COORD_MAX;
          2:       py = '0;
          default: py = '1;
        endcase
      end
    endcase
  endtask

  // Result side. Ready idles at random in stretches, with stretches of no
  // stalls at all, and after 80 headings and then every HOLD_EVERY more it
  // holds off for a long spell so that the block fills up and backs up its input.
  initial begin : heading_sink
    int stall_left;
    int stretch_left;
    int headings_seen;
    int next_hold;
    bit steady;
    stall_left    = 0;
    stretch_left  = 0;
    headings_seen = 0;
    next_hold     = 80;
    steady        = 1'b0;
    hdg.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (headings_seen >= next_hold) begin
        next_hold = next_hold + HOLD_EVERY;
        repeat (HOLD_CYCLES) begin
          hdg.ready <= 1'b0;
          @(posedge clk);
        end
      end
      if (stretch_left == 0) begin
        steady       = ($urandom_range(3) == 0);
        stretch_left = $urandom_range(20, 200);
      end
      stretch_left--;
      if (stall_left > 0) begin
        hdg.ready <= 1'b0;
        stall_left--;
      end else begin
        hdg.ready <= 1'b1;
        if (!steady && $urandom_range(2) == 0) begin
          stall_left = pick_gap();
        end
      end
      @(posedge clk);
      if (hdg.valid === 1'b1 && hdg.ready === 1'b1) begin
        sb.check_heading(hdg.heading, hdg.run_end);
        headings_seen++;
      end
    end
  end

  // Ends the run if no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((pts.valid === 1'b1 && pts.ready === 1'b1) ||
          (hdg.valid === 1'b1 && hdg.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_path_heading_from_points NOT OK");
    $finish;
  end

  // Point side: reset, a directed opening, then random paths, then drain.
  initial begin : point_source
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    int  points_sent;
    int  path_len;
    bit  steady;
    sb = new();
    rst_n           <= 1'b0;
    pts.valid       <= 1'b0;
    pts.point_x     <= '0;
    pts.point_y     <= '0;
    pts.final_point <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // A path of one point gives no heading at all.
    send_point(32'sd5, 32'sd7, 1'b1, 0);
    // Two equal points: a zero step with heading zero, and since it is the
    // only heading of the path it carries run_end and is not repeated.
    send_point('0, '0, 1'b0, 0);
    send_point('0, '0, 1'b1, 2);
    // A longer path through the coordinate extremes and the four axis
    // directions; the moves straight to the left land on the half turn, which must
    // come out as the most negative angle. Its last point repeats the
    // heading.
    send_point(COORD_MIN, COORD_MIN, 1'b0, 0);
    send_point(COORD_MAX, COORD_MAX, 1'b0, 0);
    send_point(COORD_MIN, COORD_MAX, 1'b0, 0);
    send_point(COORD_MIN, COORD_MIN, 1'b0, 3);
    send_point('0, '0, 1'b0, 0);
    send_point(UNIT, '0, 1'b0, 0);
    send_point(UNIT, UNIT, 1'b0, 0);
    send_point('0, UNIT, 1'b0, 1);
    send_point(-UNIT, UNIT, 1'b0, 0);
    send_point(-UNIT, '0, 1'b0, 0);
    send_point(-UNIT, '1, 1'b0, 0);
    send_point(32'sd1, -32'sd2, 1'b0, 0);
    send_point('0, COORD_MAX, 1'b0, 0);
    send_point(COORD_MAX, COORD_MIN, 1'b1, 0);
    // Two headings exactly, then the repeat.
    send_point(UNIT, UNIT, 1'b0, 0);
    send_point(-UNIT, -UNIT, 1'b0, 0);
    send_point('0, -UNIT, 1'b1, 0);
    points_sent = 20;

    // Random paths. A few are single points; the rest run for a handful of
    // steps. Each path either streams without gaps or idles at random.
    px = $urandom;
    py = $urandom;
    while (points_sent < POINT_TARGET) begin
      path_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 10);
      steady   = ($urandom_range(9) < 3);
      for (int k = 0; k < path_len; k++) begin
        next_point(px, py);
        send_point(px, py, (k == path_len - 1), steady ? 0 : pick_gap());
        points_sent++;
      end
    end
    pts.valid <= 1'b0;

    // Wait for every heading word still owed, then a little longer so that
    // a stray extra word would still be caught.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_path_heading_from_points OK");
    end else begin
      $display("tb_path_heading_from_points NOT OK");
    end
    $finish;
  end

endmodule
